/* hw/rtl/wmvg_pkg.sv */
// ----------------------------------------------------------------------------
// wmvg_pkg: shared types and constants of the window mean / variance gate
// Widths, window length, reciprocal for the mean and the queue entry layout.
// ----------------------------------------------------------------------------
package wmvg_pkg;

    localparam int WINDOW     = 20;
    localparam int SAMPLE_W   = 10;
    localparam int VLIM_W     = 20;
    localparam int IDX_W      = $clog2(WINDOW);
    localparam int SUM_W      = SAMPLE_W + IDX_W;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int ACC_W      = SQ_W + IDX_W;
    localparam int THR_W      = VLIM_W + IDX_W + 1;

    // Mean by multiply with a rounded-up reciprocal, exact for any sum below 2**SUM_W.
    localparam int MEAN_K     = SUM_W + 6;
    localparam int PROD_W     = SUM_W + MEAN_K;
    localparam logic [MEAN_K-1:0] MEAN_RECIP =
        MEAN_K'(((1 << MEAN_K) + WINDOW - 1) / WINDOW);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    typedef enum logic [0:0] {
        CFG_VLIMIT = 1'b0,
        CFG_CEIL   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    idx;
        logic                last;
        logic [SUM_W-1:0]    sum;
    } q_entry_t;

    typedef struct packed {
        logic [VLIM_W-1:0]   variance_limit;
        logic [SAMPLE_W-1:0] ceiling_distance;
    } cfg_t;

endpackage

/* hw/rtl/wmvg_if.sv */
// ----------------------------------------------------------------------------
// wmvg_if: stream interfaces of the window mean / variance gate
// Sample channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface wmvg_sample_if import wmvg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wmvg_result_if import wmvg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] distance;
    logic                rejected;

    modport source (output valid, output distance, output rejected, input ready);
    modport sink   (input valid, input distance, input rejected, output ready);
endinterface

/* hw/rtl/window_mean_variance_gate.sv */
// ----------------------------------------------------------------------------
// window_mean_variance_gate: windowed mean with variance rejection
// Averages WINDOW range samples, rejects noisy or too-far windows.
// ----------------------------------------------------------------------------
//  channel    | dir | payload                      | handshake
//  -----------+-----+------------------------------+--------------------------
//  samples    | in  | sample[9:0]                  | valid/ready
//  results    | out | distance[9:0], rejected      | valid/ready
//  APB config | in  | paddr[2:0], pwdata, prdata   | psel/penable, pready = 1
//
//  Samples enter at one per cycle into a four-entry queue while it is not
//  full; the compute side drains it one per cycle while it is collecting. The
//  last sample of a window starts the compute side's evaluation (reciprocal
//  multiply, one read per store entry through the single store read port,
//  square and accumulate, decide), during which the queue is not drained.
//  Reset clears counters, queue pointers and the output valid; store contents
//  are left as they are. A held result stalls only the compute side; the
//  intake keeps taking samples until the queue fills.
// ----------------------------------------------------------------------------
module window_mean_variance_gate import wmvg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    wmvg_sample_if.sink         samples,
    wmvg_result_if.source       results,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic       q_push;
    q_entry_t   q_push_entry;
    logic       q_pop;
    q_entry_t   q_head;
    logic       q_full;
    logic       q_empty;
    cfg_t       cfg_reg;
    cfg_index_t cfg_sel;
    logic       cfg_wr;

    // Configuration registers: word index taken from paddr[2].
    assign pready  = 1'b1;
    assign cfg_sel = cfg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.variance_limit   <= VLIM_W'(10);
            cfg_reg.ceiling_distance <= SAMPLE_W'(35);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                CFG_VLIMIT: cfg_reg.variance_limit   <= pwdata[VLIM_W-1:0];
                CFG_CEIL:   cfg_reg.ceiling_distance <= pwdata[SAMPLE_W-1:0];
                default:    cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            CFG_VLIMIT: prdata = PDATA_W'(cfg_reg.variance_limit);
            CFG_CEIL:   prdata = PDATA_W'(cfg_reg.ceiling_distance);
            default:    prdata = '0;
        endcase
    end

    // Intake: tag each transaction with its slot and the running sum.
    wmvg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    // Decouple intake from the variance sweep.
    wmvg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Store, mean, variance sweep and decision; owns the result register.
    wmvg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (q_head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .results (results)
    );

    // Never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // Never pop an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // After the last sample of a window, hold the queue for the mean step.
    a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.last) |=> !q_pop)
        else $error("queue popped during window evaluation");

endmodule

/* hw/rtl/wmvg_front.sv */
// ----------------------------------------------------------------------------
// wmvg_front: sample intake
// Tags each sample with its window slot, marks the last one, keeps the sum.
// ----------------------------------------------------------------------------
module wmvg_front import wmvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wmvg_sample_if.sink samples,
    input  logic        q_full,
    output logic        push,
    output q_entry_t    push_entry
);

    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_inc;
    logic             last;

    assign samples.ready = !q_full;
    assign push          = samples.valid && !q_full;

    assign last    = (count_reg == IDX_W'(WINDOW - 1));
    assign sum_inc = sum_reg + SUM_W'(samples.sample);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (push)
        begin
            count_next = last ? '0 : count_reg + IDX_W'(1);
            sum_next   = last ? '0 : sum_inc;
        end
    end

    assign push_entry.sample = samples.sample;
    assign push_entry.idx    = count_reg;
    assign push_entry.last   = last;
    assign push_entry.sum    = sum_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

/* hw/rtl/wmvg_queue.sv */
// ----------------------------------------------------------------------------
// wmvg_queue: short FIFO between intake and compute
// Holds tagged samples while the variance pass runs.
// ----------------------------------------------------------------------------
module wmvg_queue import wmvg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output logic     full,
    output logic     empty
);

    q_entry_t          slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   level_reg;

    assign full  = (level_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (level_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + (QPTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

/* hw/rtl/wmvg_back.sv */
// ----------------------------------------------------------------------------
// wmvg_back: window store, mean, variance pass and accept/reject decision
// Drains the queue into the store, then sweeps the store once per window.
// ----------------------------------------------------------------------------
module wmvg_back import wmvg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  q_entry_t      head,
    input  logic          q_empty,
    output logic          pop,
    wmvg_result_if.source results
);

    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_MEAN    = 4'b0010,
        ST_PASS    = 4'b0100,
        ST_DECIDE  = 4'b1000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic [SAMPLE_W-1:0] store [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic                sq_vld_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [IDX_W-1:0]    rd_ptr_reg;
    logic                rd_en;
    logic                pass_done_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] diff;
    logic                reject;
    logic                load_out;
    logic                out_vld_reg;
    logic [SAMPLE_W-1:0] out_dist_reg;
    logic                out_rej_reg;

    assign mean = prod_reg[MEAN_K +: SAMPLE_W];
    assign diff = (rd_data_reg >= mean) ? (rd_data_reg - mean) : (mean - rd_data_reg);

    // variance > limit  <=>  sum of squares >= (limit + 1) * WINDOW
    assign reject = (THR_W'(acc_reg) >= thr_reg) || (mean > cfg.ceiling_distance);

    assign pop      = (state_reg == ST_COLLECT) && !q_empty;
    assign rd_en    = (state_reg == ST_PASS) && !pass_done_reg;
    assign load_out = (state_reg == ST_DECIDE) && (!out_vld_reg || results.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (pop && head.last)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                state_next = ST_PASS;
            end
            ST_PASS:
            begin
                if (pass_done_reg && !rd_vld_reg && !sq_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (load_out)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Window store: one write port from the queue, one registered read port for the sweep.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            store[head.idx] <= head.sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= store[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            sum_reg <= head.sum;
        end
        if (state_reg == ST_MEAN)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(MEAN_RECIP);
        end
        if (rd_vld_reg)
        begin
            sq_reg <= SQ_W'(diff) * SQ_W'(diff);
        end
        if (state_reg == ST_MEAN)
        begin
            acc_reg <= '0;
        end
        else if (sq_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end
        thr_reg <= (THR_W'(cfg.variance_limit) + THR_W'(1)) * THR_W'(WINDOW);
        if (load_out)
        begin
            out_dist_reg <= reject ? cfg.ceiling_distance : mean;
            out_rej_reg  <= reject;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            rd_ptr_reg    <= '0;
            pass_done_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            sq_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            sq_vld_reg <= rd_vld_reg;
            if (state_reg == ST_MEAN)
            begin
                rd_ptr_reg    <= '0;
                pass_done_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                rd_ptr_reg    <= rd_ptr_reg + IDX_W'(1);
                pass_done_reg <= (rd_ptr_reg == IDX_W'(WINDOW - 1));
            end
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign results.valid    = out_vld_reg;
    assign results.distance = out_dist_reg;
    assign results.rejected = out_rej_reg;

endmodule
